FILE: rtl/core/lox_pkg.sv
// Shared constants and controller/datapath interface types for the LOX crossover engine.
package lox_pkg;

   localparam int GENE_W     = 6;
   localparam int MAX_GENES  = 64;
   localparam int POS_W      = $clog2(MAX_GENES);
   localparam int LEN_W      = 7;
   localparam int MIN_LEN    = 2;
   localparam int GENE_SPACE = 2 ** GENE_W;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   typedef struct packed {
      logic idle;
      logic mark;
      logic fill;
      logic tail;
      logic emit_load;
   } lox_cmd_type;

   typedef struct packed {
      logic trigger;
      logic mark_end;
      logic fill_end;
      logic tail_done;
      logic out_taken;
      logic out_last;
   } lox_sts_type;

endpackage

FILE: rtl/core/linear_order_crossover.sv
// Sequence: each load transfer stores one gene pair; the completing transfer runs the mark,
// fill scan and zero tail phases, then the emit phase loads the first result.
// Output: one result is held at a time and the next is loaded only after it is taken, through
// the registered read port of the child memories; new input is taken only when idle.
// Reset: synchronous; clears the load count, segment masks and control, tour_length to 64.
// Gene memories are not cleared: every entry read is written in the same crossover.
module linear_order_crossover import lox_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [LEN_W-1:0]      csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // parent_a_gene[5:0], parent_b_gene[11:6], cut_first[17:12], cut_second[23:18]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // position[5:0], child_a_gene[11:6], child_b_gene[17:12], zero[23:18]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   lox_cmd_type       cmd;
   lox_sts_type       sts;
   logic [GENE_W-1:0] position;
   logic [GENE_W-1:0] child_a_gene;
   logic [GENE_W-1:0] child_b_gene;

   lox_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   lox_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .parent_a_gene (req_tdata[GENE_W-1:0]),
      .parent_b_gene (req_tdata[2*GENE_W-1:GENE_W]),
      .cut_first     (req_tdata[3*GENE_W-1:2*GENE_W]),
      .cut_second    (req_tdata[4*GENE_W-1:3*GENE_W]),
      .rsp_tready    (rsp_tready),
      .rsp_tvalid    (rsp_tvalid),
      .position      (position),
      .child_a_gene  (child_a_gene),
      .child_b_gene  (child_b_gene),
      .last_position (rsp_tlast),
      .cmd           (cmd),
      .sts           (sts)
   );

   assign rsp_tdata = {(RSP_DATA_W - 3*GENE_W)'(0), child_b_gene, child_a_gene, position};

endmodule

FILE: rtl/core/lox_ctrl.sv
// Sequencing state machine for load, mark, fill, tail and emit phases.
module lox_ctrl import lox_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  lox_sts_type sts,
   output lox_cmd_type cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MARK  = 3'd1;
   localparam logic [2:0] S_FILL  = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_TAIL  = 3'd4;
   localparam logic [2:0] S_ERD   = 3'd5;
   localparam logic [2:0] S_ELD   = 3'd6;
   localparam logic [2:0] S_EWAIT = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (sts.trigger) state_in = S_MARK;
         end
         S_MARK: begin
            if (sts.mark_end) state_in = S_FILL;
         end
         S_FILL: begin
            if (sts.fill_end) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            state_in = S_TAIL;
         end
         S_TAIL: begin
            if (sts.tail_done) state_in = S_ERD;
         end
         S_ERD: begin
            state_in = S_ELD;
         end
         S_ELD: begin
            state_in = S_EWAIT;
         end
         S_EWAIT: begin
            if (sts.out_taken) state_in = sts.out_last ? S_IDLE : S_ELD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd           = '0;
      cmd.idle      = (state_ff == S_IDLE);
      cmd.mark      = (state_ff == S_MARK);
      cmd.fill      = (state_ff == S_FILL);
      cmd.tail      = (state_ff == S_TAIL);
      cmd.emit_load = (state_ff == S_ELD);
   end

endmodule

FILE: rtl/core/lox_datapath.sv
// Parent and child gene memories, segment masks, scan counters and result register.
module lox_datapath import lox_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [LEN_W-1:0]  csr_wdata,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [GENE_W-1:0] parent_a_gene,
   input  logic [GENE_W-1:0] parent_b_gene,
   input  logic [GENE_W-1:0] cut_first,
   input  logic [GENE_W-1:0] cut_second,
   input  logic              rsp_tready,
   output logic              rsp_tvalid,
   output logic [GENE_W-1:0] position,
   output logic [GENE_W-1:0] child_a_gene,
   output logic [GENE_W-1:0] child_b_gene,
   output logic              last_position,
   input  lox_cmd_type       cmd,
   output lox_sts_type       sts
);

   logic [GENE_W-1:0] par_a_mem [MAX_GENES];
   logic [GENE_W-1:0] par_b_mem [MAX_GENES];
   logic [GENE_W-1:0] ch_a_mem  [MAX_GENES];
   logic [GENE_W-1:0] ch_b_mem  [MAX_GENES];

   logic [LEN_W-1:0]      tour_len_ff;
   logic [POS_W-1:0]      load_cnt_ff;
   logic [POS_W-1:0]      idx_ff;
   logic [POS_W-1:0]      idx_in;
   logic [POS_W-1:0]      hi_ff;
   logic [POS_W-1:0]      free_ff;
   logic [POS_W-1:0]      fa_ff;
   logic [POS_W-1:0]      slot_a_ff;
   logic [POS_W-1:0]      slot_b_ff;
   logic [POS_W-1:0]      placed_a_ff;
   logic [POS_W-1:0]      placed_b_ff;
   logic [GENE_SPACE-1:0] mask_a_ff;
   logic [GENE_SPACE-1:0] mask_b_ff;
   logic                  mk_v_ff;
   logic [POS_W-1:0]      mk_pos_ff;
   logic                  fl_v_ff;
   logic [GENE_W-1:0]     par_a_rd_ff;
   logic [GENE_W-1:0]     par_b_rd_ff;
   logic [GENE_W-1:0]     ch_a_rd_ff;
   logic [GENE_W-1:0]     ch_b_rd_ff;
   logic                  rsp_valid_ff;
   logic [POS_W-1:0]      rsp_pos_ff;
   logic [GENE_W-1:0]     rsp_a_ff;
   logic [GENE_W-1:0]     rsp_b_ff;
   logic                  rsp_last_ff;

   logic [LEN_W-1:0]  n;
   logic [POS_W-1:0]  nm1;
   logic              req_acc;
   logic              trigger;
   logic [POS_W-1:0]  lo_raw;
   logic [POS_W-1:0]  hi_raw;
   logic [POS_W-1:0]  cut_lo;
   logic [POS_W-1:0]  cut_hi;
   logic [POS_W-1:0]  seg_free;
   logic [POS_W-1:0]  fill_start;
   logic [POS_W-1:0]  par_rd_addr;
   logic [POS_W-1:0]  ch_rd_addr;
   logic              place_a;
   logic              place_b;
   logic              tail_a;
   logic              tail_b;
   logic              adv_a;
   logic              adv_b;
   logic              wr_a_en;
   logic              wr_b_en;
   logic [POS_W-1:0]  wr_a_addr;
   logic [POS_W-1:0]  wr_b_addr;
   logic [GENE_W-1:0] wr_a_data;
   logic [GENE_W-1:0] wr_b_data;
   logic              out_taken;

   function automatic logic [POS_W-1:0] wrap_inc(input logic [POS_W-1:0] p,
                                                 input logic [POS_W-1:0] top);
      wrap_inc = (p == top) ? '0 : p + POS_W'(1);
   endfunction

   always_comb begin
      if (tour_len_ff < LEN_W'(MIN_LEN)) begin
         n = LEN_W'(MIN_LEN);
      end else if (tour_len_ff > LEN_W'(MAX_GENES)) begin
         n = LEN_W'(MAX_GENES);
      end else begin
         n = tour_len_ff;
      end
   end

   assign nm1        = POS_W'(n - LEN_W'(1));
   assign req_tready = cmd.idle;
   assign req_acc    = req_tvalid & cmd.idle;
   assign trigger    = req_acc && ((LEN_W'(load_cnt_ff) + LEN_W'(1)) >= n);

   assign lo_raw     = (cut_first > cut_second) ? POS_W'(cut_second) : POS_W'(cut_first);
   assign hi_raw     = (cut_first > cut_second) ? POS_W'(cut_first) : POS_W'(cut_second);
   assign cut_lo     = (lo_raw > nm1) ? nm1 : lo_raw;
   assign cut_hi     = (hi_raw > nm1) ? nm1 : hi_raw;
   assign seg_free   = nm1 - cut_hi + cut_lo;
   assign fill_start = wrap_inc(cut_hi, nm1);

   assign place_a = fl_v_ff && !mask_a_ff[par_b_rd_ff] && (placed_a_ff < free_ff);
   assign place_b = fl_v_ff && !mask_b_ff[par_a_rd_ff] && (placed_b_ff < free_ff);
   assign tail_a  = cmd.tail && (placed_a_ff < free_ff);
   assign tail_b  = cmd.tail && (placed_b_ff < free_ff);
   assign adv_a   = place_a | tail_a;
   assign adv_b   = place_b | tail_b;

   always_comb begin
      wr_a_en   = mk_v_ff | adv_a;
      wr_b_en   = mk_v_ff | adv_b;
      wr_a_addr = slot_a_ff;
      wr_b_addr = slot_b_ff;
      wr_a_data = '0;
      wr_b_data = '0;
      if (mk_v_ff) begin
         wr_a_addr = mk_pos_ff;
         wr_b_addr = mk_pos_ff;
         wr_a_data = par_a_rd_ff;
         wr_b_data = par_b_rd_ff;
      end else begin
         if (place_a) wr_a_data = par_b_rd_ff;
         if (place_b) wr_b_data = par_a_rd_ff;
      end
   end

   assign out_taken   = rsp_valid_ff & rsp_tready;
   assign par_rd_addr = cmd.mark ? idx_ff : fa_ff;
   assign ch_rd_addr  = (out_taken && !rsp_last_ff) ? idx_ff + POS_W'(1) : idx_ff;

   always_comb begin
      sts           = '0;
      sts.trigger   = trigger;
      sts.mark_end  = (idx_ff == hi_ff);
      sts.fill_end  = (idx_ff == nm1);
      sts.tail_done = (placed_a_ff >= free_ff) && (placed_b_ff >= free_ff);
      sts.out_taken = out_taken;
      sts.out_last  = rsp_last_ff;
   end

   always_comb begin
      idx_in = idx_ff;
      if (trigger) begin
         idx_in = cut_lo;
      end else if (cmd.mark) begin
         idx_in = sts.mark_end ? '0 : idx_ff + POS_W'(1);
      end else if (cmd.fill) begin
         idx_in = sts.fill_end ? '0 : idx_ff + POS_W'(1);
      end else if (out_taken && !rsp_last_ff) begin
         idx_in = idx_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         par_a_mem[load_cnt_ff] <= parent_a_gene;
         par_b_mem[load_cnt_ff] <= parent_b_gene;
      end
      par_a_rd_ff <= par_a_mem[par_rd_addr];
      par_b_rd_ff <= par_b_mem[par_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_a_en) ch_a_mem[wr_a_addr] <= wr_a_data;
      if (wr_b_en) ch_b_mem[wr_b_addr] <= wr_b_data;
      ch_a_rd_ff <= ch_a_mem[ch_rd_addr];
      ch_b_rd_ff <= ch_b_mem[ch_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tour_len_ff  <= LEN_W'(MAX_GENES);
         load_cnt_ff  <= '0;
         mask_a_ff    <= '0;
         mask_b_ff    <= '0;
         mk_v_ff      <= 1'b0;
         fl_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) tour_len_ff <= csr_wdata;
         if (req_acc) load_cnt_ff <= trigger ? '0 : load_cnt_ff + POS_W'(1);
         mk_v_ff <= cmd.mark;
         fl_v_ff <= cmd.fill;
         if (trigger) begin
            mask_a_ff <= '0;
            mask_b_ff <= '0;
         end else if (mk_v_ff) begin
            mask_a_ff <= mask_a_ff | (GENE_SPACE'(1) << par_a_rd_ff);
            mask_b_ff <= mask_b_ff | (GENE_SPACE'(1) << par_b_rd_ff);
         end
         if (cmd.emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (out_taken) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      mk_pos_ff <= idx_ff;
      if (trigger) begin
         hi_ff       <= cut_hi;
         free_ff     <= seg_free;
         fa_ff       <= fill_start;
         slot_a_ff   <= fill_start;
         slot_b_ff   <= fill_start;
         placed_a_ff <= '0;
         placed_b_ff <= '0;
      end else begin
         if (cmd.fill) fa_ff <= wrap_inc(fa_ff, nm1);
         if (adv_a) begin
            slot_a_ff   <= wrap_inc(slot_a_ff, nm1);
            placed_a_ff <= placed_a_ff + POS_W'(1);
         end
         if (adv_b) begin
            slot_b_ff   <= wrap_inc(slot_b_ff, nm1);
            placed_b_ff <= placed_b_ff + POS_W'(1);
         end
      end
      if (cmd.emit_load) begin
         rsp_pos_ff  <= idx_ff;
         rsp_a_ff    <= ch_a_rd_ff;
         rsp_b_ff    <= ch_b_rd_ff;
         rsp_last_ff <= (idx_ff == nm1);
      end
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign position      = GENE_W'(rsp_pos_ff);
   assign child_a_gene  = rsp_a_ff;
   assign child_b_gene  = rsp_b_ff;
   assign last_position = rsp_last_ff;

endmodule

FILE: rtl/core/lox_checker.sv
// Port-level assertions for the LOX crossover engine, bound to the top level.
module lox_checker import lox_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready while a result is pending");

   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled result changed");

   a_last_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (req_tready && !rsp_tvalid))
      else $error("no return to idle after final transfer");

endmodule

bind linear_order_crossover lox_checker u_lox_checker (.*);

FILE: verif/tb_linear_order_crossover.sv
// Self-checking testbench for the linear order crossover engine, with a predicting scoreboard.
module tb_linear_order_crossover;
   timeunit 1ns;
   timeprecision 1ps;
   import lox_pkg::*;

   typedef logic [GENE_W-1:0] gene_t;

   typedef struct packed {
      gene_t cut_second;
      gene_t cut_first;
      gene_t gene_b;
      gene_t gene_a;
   } pair_word_t;

   typedef struct packed {
      logic [RSP_DATA_W-3*GENE_W-1:0] pad;
      gene_t                          child_b;
      gene_t                          child_a;
      logic [POS_W-1:0]               position;
   } child_word_t;

   typedef struct packed {
      child_word_t word;
      logic        last;
   } child_entry_t;

   class offspring_checker;
      logic [LEN_W-1:0] tour_length;
      gene_t            parent[2][MAX_GENES];
      gene_t            child[2][MAX_GENES];
      int               load_pos;
      int               mismatches;
      child_entry_t     awaited_children[$];

      function new();
         tour_length = MAX_GENES;
         load_pos    = 0;
         mismatches  = 0;
      endfunction

      function int span();
         if (tour_length < MIN_LEN) return MIN_LEN;
         if (tour_length > MAX_GENES) return MAX_GENES;
         return int'(tour_length);
      endfunction

      function void splice(int side, int n, int lo, int hi);
         logic [GENE_SPACE-1:0] kept;
         int                    slot, placed, free_slots;
         gene_t                 g;
         kept = '0;
         for (int i = 0; i < n; i++) child[side][i] = '0;
         for (int i = lo; i <= hi; i++) begin
            child[side][i] = parent[side][i];
            kept[parent[side][i]] = 1'b1;
         end
         free_slots = n - (hi - lo + 1);
         slot       = (hi + 1) % n;
         placed     = 0;
         for (int i = 0; i < n && placed < free_slots; i++) begin
            g = parent[1-side][(hi + 1 + i) % n];
            if (!kept[g]) begin
               child[side][slot] = g;
               slot = (slot + 1) % n;
               placed++;
            end
         end
      endfunction

      function void load_gene_pair(pair_word_t w);
         int           n, lo, hi, t;
         child_entry_t e;
         n = span();
         parent[0][load_pos] = w.gene_a;
         parent[1][load_pos] = w.gene_b;
         load_pos++;
         if (load_pos < n) return;
         load_pos = 0;
         lo = w.cut_first;
         hi = w.cut_second;
         if (lo > hi) begin
            t  = lo;
            lo = hi;
            hi = t;
         end
         if (lo > n - 1) lo = n - 1;
         if (hi > n - 1) hi = n - 1;
         splice(0, n, lo, hi);
         splice(1, n, lo, hi);
         for (int p = 0; p < n; p++) begin
            e.word.pad      = '0;
            e.word.child_b  = child[1][p];
            e.word.child_a  = child[0][p];
            e.word.position = POS_W'(p);
            e.last          = (p == n - 1);
            awaited_children.push_back(e);
         end
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) $display("mismatch: %s", msg);
      endfunction

      function void check_child_pair(child_word_t w, logic last);
         child_entry_t e;
         if (awaited_children.size() == 0) begin
            flag($sformatf("unexpected transfer: pos %0d child_a %0d child_b %0d last %0b",
                           w.position, w.child_a, w.child_b, last));
            return;
         end
         e = awaited_children.pop_front();
         if (w !== e.word || last !== e.last)
            flag($sformatf({"pos %0d/%0d child_a %0d/%0d child_b %0d/%0d last %0b/%0b",
                            " pad %0h/%0h (expected/actual)"},
                           e.word.position, w.position, e.word.child_a, w.child_a,
                           e.word.child_b, w.child_b, e.last, last, e.word.pad, w.pad));
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [LEN_W-1:0]      csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   pair_word_t            req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   int    sender_idle_pct   = 33;
   int    receiver_idle_pct = 51;
   int    hold_asked        = 0;
   int    hold_served       = 0;
   int    hold_left         = 0;
   int    random_items      = 0;
   gene_t tour_a[MAX_GENES];
   gene_t tour_b[MAX_GENES];

   offspring_checker board = new();

   linear_order_crossover dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_child_pair(rsp_tdata, rsp_tlast);
      if (hold_served != hold_asked) begin
         hold_served = hold_asked;
         hold_left   = 300;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   function automatic pair_word_t pack_pair(gene_t a, gene_t b, gene_t c1, gene_t c2);
      pair_word_t w;
      w.gene_a     = a;
      w.gene_b     = b;
      w.cut_first  = c1;
      w.cut_second = c2;
      return w;
   endfunction

   function automatic void pick_idle();
      if (random_items < 70) begin
         sender_idle_pct   = 33;
         receiver_idle_pct = 51;
      end else if (random_items < 140) begin
         sender_idle_pct   = 51;
         receiver_idle_pct = 33;
      end else begin
         sender_idle_pct   = 0;
         receiver_idle_pct = 0;
      end
   endfunction

   function automatic void shape_parents(int n, bit noisy);
      gene_t pool[MAX_GENES];
      gene_t t;
      int    j;
      for (int i = 0; i < MAX_GENES; i++) pool[i] = gene_t'(i);
      for (int i = MAX_GENES - 1; i > 0; i--) begin
         j       = $urandom_range(0, i);
         t       = pool[i];
         pool[i] = pool[j];
         pool[j] = t;
      end
      for (int i = 0; i < n; i++) tour_a[i] = pool[i];
      for (int i = n - 1; i > 0; i--) begin
         j       = $urandom_range(0, i);
         t       = pool[i];
         pool[i] = pool[j];
         pool[j] = t;
      end
      for (int i = 0; i < n; i++) tour_b[i] = pool[i];
      if (noisy) begin
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 2) == 0) tour_a[i] = gene_t'($urandom_range(0, 63));
            if ($urandom_range(0, 2) == 0) tour_b[i] = gene_t'($urandom_range(0, 63));
         end
      end
   endfunction

   task automatic send_pair(pair_word_t w);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      do @(posedge clock); while (!req_tready);
      board.load_gene_pair(w);
   endtask

   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      while (board.awaited_children.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_length(logic [LEN_W-1:0] v);
      wait_quiet();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      board.tour_length = v;
   endtask

   task automatic send_tour(int n, bit noisy, int partial);
      int    start, total, pos;
      gene_t c1, c2;
      shape_parents(n, noisy);
      start = board.load_pos;
      total = (partial > 0) ? partial : ((start < n) ? n - start : 1);
      for (int i = 0; i < total; i++) begin
         pick_idle();
         pos = start + i;
         c1  = gene_t'($urandom_range(0, 63));
         c2  = gene_t'($urandom_range(0, 63));
         if (i == total - 1 && partial == 0 && $urandom_range(0, 3) != 0) begin
            c1 = gene_t'($urandom_range(0, n - 1));
            c2 = gene_t'($urandom_range(0, n - 1));
         end
         send_pair(pack_pair(tour_a[pos], tour_b[pos], c1, c2));
         random_items++;
      end
   endtask

   initial begin
      int len_value, n, tours;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_length(0);
      send_pair(pack_pair(63, 0, 17, 4));
      send_pair(pack_pair(0, 63, 63, 0));
      send_pair(pack_pair(5, 9, 9, 9));
      send_pair(pack_pair(9, 5, 0, 0));
      write_length(1);
      send_pair(pack_pair(7, 7, 0, 0));
      send_pair(pack_pair(7, 7, 1, 1));
      write_length(3);
      send_pair(pack_pair(2, 40, 0, 0));
      send_pair(pack_pair(63, 2, 0, 0));
      send_pair(pack_pair(40, 63, 50, 40));
      write_length(5);
      send_pair(pack_pair(3, 9, 0, 0));
      send_pair(pack_pair(1, 9, 0, 0));
      send_pair(pack_pair(4, 9, 0, 0));
      send_pair(pack_pair(0, 9, 0, 0));
      send_pair(pack_pair(2, 9, 3, 1));
      write_length(4);
      send_pair(pack_pair(11, 22, 0, 0));
      send_pair(pack_pair(22, 11, 0, 0));
      write_length(2);
      send_pair(pack_pair(33, 44, 1, 0));

      for (int phase = 0; random_items < 200 || phase < 3; phase++) begin
         if (phase == 1) len_value = 127;
         else if (phase == 2) len_value = 64;
         else if ($urandom_range(0, 7) == 0) len_value = $urandom_range(13, 40);
         else len_value = $urandom_range(0, 12);
         write_length(LEN_W'(len_value));
         n = board.span();
         if (phase == 0) hold_asked++;
         if (phase == 0) tours = 2;
         else tours = (n > 12) ? 1 : $urandom_range(1, 4);
         repeat (tours) send_tour(n, ($urandom_range(0, 4) == 0), 0);
         if ($urandom_range(0, 2) == 0) send_tour(n, 1'b0, $urandom_range(1, n - 1));
      end

      wait_quiet();
      repeat (40) @(posedge clock);
      if (board.mismatches == 0 && board.awaited_children.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
